### design/md5_pkg.sv
// md5 digest package: codes, widths, round tables and round helper functions
`timescale 1ns / 1ps

package md5_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int WORDS    = 16;
    localparam int WADDR_W  = 4;
    localparam int ROUNDS   = 64;
    localparam int ROUND_W  = 6;
    localparam int FILL_W   = 6;
    localparam int LEN_W    = 61;
    localparam int IDX_W    = 2;

    // item codes
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // word positions of the length field in the last block
    localparam logic [WADDR_W-1:0] LEN_LO_WORD = 4'd14;
    localparam logic [WADDR_W-1:0] LEN_HI_WORD = 4'd15;
    localparam logic [WADDR_W-1:0] LAST_WORD   = 4'd15;
    localparam logic [IDX_W-1:0]   LAST_INDEX  = 2'd3;
    localparam logic [FILL_W-1:0]  FILL_FULL   = 6'd63;
    localparam logic [FILL_W-1:0]  LEN_START   = 6'd56;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 6'd63;
    localparam logic [BYTE_W-1:0]  PAD_BYTE    = 8'h80;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [WORD_W-1:0] SINE_TAB [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_RND_A = 7'b0001000,
        S_RND_B = 7'b0010000,
        S_FOLD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // message word used by a round
    function automatic logic [WADDR_W-1:0] f_sel(input logic [ROUND_W-1:0] round);
        logic [7:0] x;
        case (round[5:4])
            2'd0:    x = {2'b00, round};
            2'd1:    x = 8'({2'b00, round} * 8'd5 + 8'd1);
            2'd2:    x = 8'({2'b00, round} * 8'd3 + 8'd5);
            2'd3:    x = 8'({2'b00, round} * 8'd7);
            default: x = 8'd0;
        endcase
        return x[WADDR_W-1:0];
    endfunction

    function automatic logic [4:0] f_rot(input logic [ROUND_W-1:0] round);
        logic [4:0] s;
        case ({round[5:4], round[1:0]})
            4'h0:    s = 5'd7;
            4'h1:    s = 5'd12;
            4'h2:    s = 5'd17;
            4'h3:    s = 5'd22;
            4'h4:    s = 5'd5;
            4'h5:    s = 5'd9;
            4'h6:    s = 5'd14;
            4'h7:    s = 5'd20;
            4'h8:    s = 5'd4;
            4'h9:    s = 5'd11;
            4'ha:    s = 5'd16;
            4'hb:    s = 5'd23;
            4'hc:    s = 5'd6;
            4'hd:    s = 5'd10;
            4'he:    s = 5'd15;
            4'hf:    s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] f_mix(input logic [1:0] grp,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] m;
        case (grp)
            2'd0:    m = (b & c) | (~b & d);
            2'd1:    m = (d & b) | (~d & c);
            2'd2:    m = b ^ c ^ d;
            2'd3:    m = c ^ (b | ~d);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

### design/md5_if.sv
// request channel interfaces for the md5 digest block
`timescale 1ns / 1ps

interface md5_in_if;
    import md5_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface md5_out_if;
    import md5_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  word_index;
    logic              result_last;

    modport source (output valid, output digest_word, output word_index,
                    output result_last, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input result_last, output ready);
endinterface

### design/md5_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/md5_message_digest_top.sv
// md5 digest top level: byte packing, padding sequencer and iterative round unit
//
//  channel | dir | fields                                   | accepted when
//  i_in    | in  | mode, data_byte                          | valid & ready
//  o_out   | out | digest_word, word_index, result_last     | valid & ready
//
// an absorb is accepted while idle; the byte that fills a block holds ready low through
// one load, 64 rounds (S_RND_A then S_RND_B each) through the shared round unit, and one fold
// a finish writes 16 - (fill / 4) padding words, compresses, repeats once with
// 16 more padding words when fewer than 9 bytes were free, then shows four words
// sync active-low reset restores the initial chaining words and clears the counters
// ready stays low from a finish until the last digest word is taken
`timescale 1ns / 1ps

module md5_message_digest_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    md5_in_if.sink    i_in,
    md5_out_if.source o_out
);
    import md5_pkg::*;

    t_state                r_state, n_state;
    logic [FILL_W-1:0]     r_fill;
    logic [LEN_W-1:0]      r_msg;
    logic [WORD_W-1:0]     r_chain [4];
    logic [23:0]           r_acc;
    logic [WORD_W-1:0]     r_a, r_b, r_c, r_d, r_t;
    logic [ROUND_W-1:0]    r_round;
    logic [WADDR_W-1:0]    r_widx;
    logic                  r_mark;
    logic                  r_len_blk;
    logic                  r_fin;
    logic [IDX_W-1:0]      r_oidx;

    logic                  in_acc;
    logic                  out_acc;
    logic                  ram_we;
    logic [WADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WADDR_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     mark_word;
    logic [63:0]           bit_len;
    logic [63:0]           rot_dbl;
    logic [ROUND_W-1:0]    next_round;

    assign in_acc     = i_in.valid & i_in.ready;
    assign out_acc    = o_out.valid & o_out.ready;
    assign bit_len    = {r_msg, 3'b000};
    assign next_round = r_round + 1'b1;
    assign rot_dbl    = {r_t, r_t} << f_rot(r_round);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = r_chain[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.result_last = (r_oidx == LAST_INDEX);

    // word holding the 0x80 marker after the bytes already packed
    always_comb begin
        case (r_fill[1:0])
            2'd0:    mark_word = {24'h0, PAD_BYTE};
            2'd1:    mark_word = {16'h0, PAD_BYTE, r_acc[7:0]};
            2'd2:    mark_word = {8'h0, PAD_BYTE, r_acc[15:0]};
            2'd3:    mark_word = {PAD_BYTE, r_acc[23:0]};
            default: mark_word = '0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = '0;
        case (r_state)
            S_IDLE: begin
                ram_we    = in_acc && (i_in.mode == MODE_ABSORB) && (r_fill[1:0] == 2'd3);
                ram_waddr = r_fill[5:2];
                ram_wdata = {i_in.data_byte, r_acc};
            end
            S_PAD: begin
                ram_we = 1'b1;
                if (r_mark) begin
                    ram_wdata = mark_word;
                end else if (r_len_blk && r_widx == LEN_LO_WORD) begin
                    ram_wdata = bit_len[31:0];
                end else if (r_len_blk && r_widx == LEN_HI_WORD) begin
                    ram_wdata = bit_len[63:32];
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // prefetch the message word of the next round
    assign ram_raddr = (r_state == S_LOAD) ? f_sel('0) : f_sel(next_round);

    md5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_FINISH) begin
                        n_state = S_PAD;
                    end else if (r_fill == FILL_FULL) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PAD: begin
                if (r_widx == LAST_WORD) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:  n_state = S_RND_A;
            S_RND_A: n_state = S_RND_B;
            S_RND_B: begin
                n_state = (r_round == LAST_ROUND) ? S_FOLD : S_RND_A;
            end
            S_FOLD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_len_blk) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (out_acc && r_oidx == LAST_INDEX) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_msg      <= '0;
            r_fin      <= 1'b0;
            r_oidx     <= '0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.mode == MODE_ABSORB) begin
                        r_fill <= r_fill + 1'b1;
                        r_msg  <= r_msg + 1'b1;
                        r_fin  <= 1'b0;
                    end else if (in_acc) begin
                        r_fin <= 1'b1;
                    end
                end
                S_FOLD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == LAST_INDEX) begin
                            r_fill     <= '0;
                            r_msg      <= '0;
                            r_fin      <= 1'b0;
                            r_chain[0] <= IV_A;
                            r_chain[1] <= IV_B;
                            r_chain[2] <= IV_C;
                            r_chain[3] <= IV_D;
                        end
                    end
                end
                default: begin
                    r_fin <= r_fin;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.mode == MODE_ABSORB) begin
                    case (r_fill[1:0])
                        2'd0:    r_acc[7:0]   <= i_in.data_byte;
                        2'd1:    r_acc[15:8]  <= i_in.data_byte;
                        2'd2:    r_acc[23:16] <= i_in.data_byte;
                        default: r_acc        <= r_acc;
                    endcase
                end else if (in_acc) begin
                    r_widx    <= r_fill[5:2];
                    r_mark    <= 1'b1;
                    // marker and length fit when at most 55 bytes are buffered
                    r_len_blk <= (r_fill < LEN_START);
                end
            end
            S_PAD: begin
                r_mark <= 1'b0;
                r_widx <= r_widx + 1'b1;
            end
            S_LOAD: begin
                r_a     <= r_chain[0];
                r_b     <= r_chain[1];
                r_c     <= r_chain[2];
                r_d     <= r_chain[3];
                r_round <= '0;
            end
            S_RND_A: begin
                r_t <= f_mix(r_round[5:4], r_b, r_c, r_d) + r_a
                       + SINE_TAB[r_round] + ram_rdata;
            end
            S_RND_B: begin
                r_a     <= r_d;
                r_d     <= r_c;
                r_c     <= r_b;
                r_b     <= r_b + rot_dbl[63:32];
                r_round <= next_round;
            end
            S_FOLD: begin
                // second padding block starts from word zero with the length
                r_widx    <= '0;
                r_mark    <= 1'b0;
                r_len_blk <= 1'b1;
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

endmodule

### design/md5_checker.sv
// port-level checker for the md5 digest block and its bind
`timescale 1ns / 1ps

module md5_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [md5_pkg::WORD_W-1:0] i_out_word,
    input logic [md5_pkg::IDX_W-1:0]  i_out_index,
    input logic                      i_out_last
);
    import md5_pkg::*;

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
                                        && $stable(i_out_index))
        else $error("digest word changed while stalled");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == LAST_INDEX)))
        else $error("last flag does not match word index");

    // the four words follow back to back in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && (i_out_index == $past(i_out_index) + 2'd1))
        else $error("digest words out of order");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request taken while digest pending");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid)
        else $error("extra digest word after last");

endmodule

bind md5_message_digest_top md5_checker u_md5_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.digest_word),
    .i_out_index (o_out.word_index),
    .i_out_last  (o_out.result_last)
);

### tb/tb_md5_message_digest_top.sv
// testbench for the md5 digest block: byte messages in, predicted digest words checked out
`timescale 1ns / 1ps

module tb_md5_message_digest_top;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int IDLE_PCT     = 22;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int SHIFT_AMT [4][4] = '{
        '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
    };

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_digest_beat;

    logic clk;
    logic rst_n;

    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_message_digest_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted hash state
    logic [WORD_W-1:0] chain_q [4];
    logic [BYTE_W-1:0] msg_block [64];
    logic [FILL_W-1:0] block_fill;
    logic [LEN_W-1:0]  msg_len;

    t_digest_beat digest_expect_q [$];

    int  error_count  = 0;
    int  cycle_count  = 0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;
    int  hold_req     = 0;
    int  hold_ack     = 0;
    int  hold_left    = 0;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void md5_reset_state();
        chain_q[0] = 32'h67452301;
        chain_q[1] = 32'hefcdab89;
        chain_q[2] = 32'h98badcfe;
        chain_q[3] = 32'h10325476;
        block_fill = '0;
        msg_len    = '0;
    endfunction

    function automatic void md5_compress();
        logic [WORD_W-1:0] w [16];
        logic [WORD_W-1:0] a, b, c, d, f, t;
        int g;
        int s;
        for (int i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        end
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = f + a + ROUND_K[r] + w[g];
            s = SHIFT_AMT[r / 16][r % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        chain_q[0] = chain_q[0] + a;
        chain_q[1] = chain_q[1] + b;
        chain_q[2] = chain_q[2] + c;
        chain_q[3] = chain_q[3] + d;
    endfunction

    // fold one accepted request into the predicted state
    function automatic void md5_take_request(input logic mode, input logic [BYTE_W-1:0] data);
        logic [63:0] bit_len;
        t_digest_beat beat;
        int pos;
        if (mode == MODE_ABSORB) begin
            msg_block[block_fill] = data;
            block_fill = block_fill + 1'b1;
            msg_len    = msg_len + 1'b1;
            if (block_fill == '0) begin
                md5_compress();
            end
            return;
        end
        bit_len = {msg_len, 3'b000};
        pos = int'(block_fill);
        msg_block[pos] = 8'h80;
        pos++;
        // no room for the length field: close this block with zeros first
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            md5_compress();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int k = 0; k < 8; k++) begin
            msg_block[56+k] = bit_len[8*k +: 8];
        end
        md5_compress();
        for (int k = 0; k < 4; k++) begin
            beat.word  = chain_q[k];
            beat.index = IDX_W'(k);
            beat.last  = (k == 3);
            digest_expect_q.push_back(beat);
        end
        md5_reset_state();
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic mode, input logic [BYTE_W-1:0] data);
        logic took;
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.data_byte <= data;
        took = 1'b0;
        // ready is settled by the falling edge and holds through the next rising edge
        while (!took) begin
            @(negedge clk);
            took = (in_ch.ready === 1'b1);
            @(posedge clk);
        end
        md5_take_request(mode, data);
    endtask

    task automatic stop_requests();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_message(input int nbytes);
        repeat (nbytes) send_request(MODE_ABSORB, 8'($urandom_range(255)));
        send_request(MODE_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic test_known_messages();
        // empty message, finish byte must be ignored
        send_request(MODE_FINISH, 8'hff);
        send_request(MODE_ABSORB, 8'h00);
        send_request(MODE_FINISH, 8'h00);
        send_request(MODE_ABSORB, 8'hff);
        send_request(MODE_FINISH, 8'h5a);
        send_request(MODE_ABSORB, 8'h61);
        send_request(MODE_ABSORB, 8'h62);
        send_request(MODE_ABSORB, 8'h63);
        send_request(MODE_FINISH, 8'ha5);
        send_request(MODE_ABSORB, 8'h00);
        send_request(MODE_ABSORB, 8'hff);
        send_request(MODE_ABSORB, 8'h80);
        send_request(MODE_ABSORB, 8'h7f);
        send_request(MODE_ABSORB, 8'h01);
        send_request(MODE_FINISH, 8'h3c);
    endtask

    task automatic test_padding_split();
        // lengths where the pad just fits, just spills into an extra block, or ends a block
        send_message(55);
        send_message(56);
        send_message(63);
    endtask

    task automatic test_output_stall();
        hold_req <= hold_req + 1;
        send_message(5);
        send_message(3);
    endtask

    task automatic test_drain_pause();
        send_message(4);
        stop_requests();
        wait (digest_expect_q.size() == 0);
        @(posedge clk);
        send_message(2);
        stop_requests();
        wait (digest_expect_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic test_streaming();
        src_idle_on = 1'b0;
        sink_idle_on <= 1'b0;
        send_message(64);
        src_idle_on = 1'b1;
        sink_idle_on <= 1'b1;
    endtask

    task automatic test_random_messages();
        int items;
        int msg_bytes;
        items = 0;
        while (items < 20) begin
            msg_bytes = $urandom_range(6);
            send_message(msg_bytes);
            items += msg_bytes + 1;
        end
    endtask

    // output side ready, with a counted hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (sink_idle_on) begin
            out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(negedge clk) begin : digest_check
        t_digest_beat want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (digest_expect_q.size() == 0) begin
                report_mismatch("unexpected digest word", out_ch.digest_word, '0);
            end else begin
                want = digest_expect_q.pop_front();
                if (out_ch.digest_word !== want.word) begin
                    report_mismatch("digest_word", out_ch.digest_word, want.word);
                end
                if (out_ch.word_index !== want.index) begin
                    report_mismatch("word_index", 32'(out_ch.word_index), 32'(want.index));
                end
                if (out_ch.result_last !== want.last) begin
                    report_mismatch("result_last", 32'(out_ch.result_last), 32'(want.last));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_ABSORB;
        in_ch.data_byte = '0;
        md5_reset_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_known_messages();
        test_padding_split();
        test_output_stall();
        test_drain_pause();
        test_streaming();
        test_random_messages();

        stop_requests();
        wait (digest_expect_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
